/* src/rc5irtx_pkg.sv */
`timescale 1ns / 1ps

package rc5irtx_pkg;

    // default width of the carrier tick counter
    localparam int TICK_COUNT_WIDTH = 16;

    // configuration register widths and reset values
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam logic [7:0]  SENDER_MODE_RST   = 8'd0;
    localparam logic [7:0]  ACTIVE_HALF_RST   = 8'd32;
    localparam logic [7:0]  INACTIVE_HALF_RST = 8'd32;
    localparam logic [15:0] GAP_TICKS_RST     = 16'd3200;

    // frame layout
    localparam int FRAME_BITS = 14;
    localparam logic [1:0] START_BITS = 2'b11;
    localparam logic [3:0] LAST_BIT_POS = 4'd13;

    // input item kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_SENDER_MODE   = 2'd0,
        CFG_ACTIVE_HALF   = 2'd1,
        CFG_INACTIVE_HALF = 2'd2,
        CFG_GAP_TICKS     = 2'd3
    } t_cfg_idx;

    // segment phase of the transmitter
    typedef enum logic [2:0] {
        PH_BIT   = 3'b001,
        PH_TRAIL = 3'b010,
        PH_GAP   = 3'b100
    } t_phase;

    // result item flags
    typedef struct packed {
        logic request_dropped;
        logic sequence_done;
        logic busy_res;
        logic carrier_on;
    } t_result;

endpackage

/* src/rc5irtx_skid.sv */
`timescale 1ns / 1ps

module rc5irtx_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rc5irtx_pkg::t_result i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rc5irtx_pkg::t_result o_data
);

    logic                 r_main_valid;
    logic                 r_skid_valid;
    rc5irtx_pkg::t_result r_main;
    rc5irtx_pkg::t_result r_skid;
    logic                 w_accept;

    // ready comes straight from a register
    assign o_ready  = !r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_data   = r_main;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!r_main_valid || i_ready) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (w_accept) begin
            r_skid <= i_data;
        end
    end

endmodule

/* src/rc5_ir_frame_transmitter.sv */
`timescale 1ns / 1ps

// output: each result item is registered in the output buffer before it is offered
// throughput: one item per cycle when not stalled by a full output buffer;
//   single-pass step logic feeds a two-entry buffer whose ready is registered
// reset: synchronous active-low i_rst_n clears the state, loads register
//   defaults and empties the output buffer; no clearing pass

module rc5_ir_frame_transmitter #(
    parameter int TICK_COUNT_WIDTH = rc5irtx_pkg::TICK_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [rc5irtx_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [rc5irtx_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // address[4:0], command[10:5],
                                       // required_mode[18:11], repeat_count[26:19]
    input  logic [0:0]  s_axis_tuser,  // opcode[0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // carrier_on[0], busy_res[1],
                                       // sequence_done[2], request_dropped[3]
);

    localparam int CW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;
    typedef logic [CW-1:0] t_cmp;
    typedef logic [TICK_COUNT_WIDTH-1:0] t_tick;
    localparam t_tick TICK_MAX = '1;

    // configuration registers
    logic [7:0]  r_sender_mode;
    logic [7:0]  r_active_half;
    logic [7:0]  r_inactive_half;
    logic [15:0] r_gap_ticks;

    // transmitter state
    logic                  r_sending,      n_sending;
    logic [13:0]           r_frame_word,   n_frame_word;
    logic [3:0]            r_bit_pos,      n_bit_pos;
    logic                  r_second_half,  n_second_half;
    rc5irtx_pkg::t_phase   r_phase,        n_phase;
    t_tick                 r_tick_count,   n_tick_count;
    logic [7:0]            r_repeats_left, n_repeats_left;
    logic                  r_toggle,       n_toggle;
    rc5irtx_pkg::t_result  n_result;

    logic        w_accept;
    logic        w_op;
    logic [4:0]  w_addr;
    logic [5:0]  w_cmd;
    logic [7:0]  w_req_mode;
    logic [7:0]  w_reps;
    logic [3:0]  w_bit_idx;
    logic        w_bit;
    logic        w_carrier;
    t_cmp        w_len;
    t_tick       w_tick_inc;
    logic        w_seg_end;
    logic [7:0]  w_reps_dec;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_op       = s_axis_tuser[0];
    assign w_addr     = s_axis_tdata[4:0];
    assign w_cmd      = s_axis_tdata[10:5];
    assign w_req_mode = s_axis_tdata[18:11];
    assign w_reps     = s_axis_tdata[26:19];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sender_mode   <= rc5irtx_pkg::SENDER_MODE_RST;
            r_active_half   <= rc5irtx_pkg::ACTIVE_HALF_RST;
            r_inactive_half <= rc5irtx_pkg::INACTIVE_HALF_RST;
            r_gap_ticks     <= rc5irtx_pkg::GAP_TICKS_RST;
        end else if (i_cfg_we) begin
            case (rc5irtx_pkg::t_cfg_idx'(i_cfg_idx))
                rc5irtx_pkg::CFG_SENDER_MODE:   r_sender_mode   <= i_cfg_data[7:0];
                rc5irtx_pkg::CFG_ACTIVE_HALF:   r_active_half   <= i_cfg_data[7:0];
                rc5irtx_pkg::CFG_INACTIVE_HALF: r_inactive_half <= i_cfg_data[7:0];
                rc5irtx_pkg::CFG_GAP_TICKS:     r_gap_ticks     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // current manchester half and segment length
    assign w_bit_idx = rc5irtx_pkg::LAST_BIT_POS - r_bit_pos;
    assign w_bit     = r_frame_word[w_bit_idx];
    assign w_carrier = r_second_half ? w_bit : !w_bit;

    always_comb begin
        case (r_phase)
            rc5irtx_pkg::PH_BIT:   w_len = w_carrier ? t_cmp'(r_active_half)
                                                     : t_cmp'(r_inactive_half);
            rc5irtx_pkg::PH_GAP:   w_len = t_cmp'(r_gap_ticks);
            rc5irtx_pkg::PH_TRAIL: w_len = t_cmp'(r_inactive_half);
            default:               w_len = t_cmp'(r_inactive_half);
        endcase
    end

    // saturating tick count
    assign w_tick_inc = (r_tick_count != TICK_MAX) ? r_tick_count + 1'b1 : r_tick_count;
    assign w_seg_end  = (t_cmp'(w_tick_inc) >= w_len) || (w_tick_inc == TICK_MAX);
    assign w_reps_dec = r_repeats_left - 8'd1;

    // one item step
    always_comb begin
        n_sending      = r_sending;
        n_frame_word   = r_frame_word;
        n_bit_pos      = r_bit_pos;
        n_second_half  = r_second_half;
        n_phase        = r_phase;
        n_tick_count   = r_tick_count;
        n_repeats_left = r_repeats_left;
        n_toggle       = r_toggle;
        n_result       = '0;

        if (w_op == rc5irtx_pkg::OP_REQUEST) begin
            if (r_sending) begin
                n_result.request_dropped = 1'b1;
            end else begin
                n_toggle = !r_toggle;
                if ((r_sender_mode >= w_req_mode) && (w_reps != 8'd0)) begin
                    n_frame_word   = {rc5irtx_pkg::START_BITS, !r_toggle, w_addr, w_cmd};
                    n_repeats_left = w_reps;
                    n_sending      = 1'b1;
                    n_bit_pos      = '0;
                    n_second_half  = 1'b0;
                    n_phase        = rc5irtx_pkg::PH_BIT;
                    n_tick_count   = '0;
                end
            end
        end else if (r_sending) begin
            if (r_phase == rc5irtx_pkg::PH_BIT) begin
                n_result.carrier_on = w_carrier;
            end
            n_tick_count = w_tick_inc;
            if (w_seg_end) begin
                n_tick_count = '0;
                case (r_phase)
                    rc5irtx_pkg::PH_BIT: begin
                        if (!r_second_half) begin
                            n_second_half = 1'b1;
                        end else begin
                            n_second_half = 1'b0;
                            if (r_bit_pos >= rc5irtx_pkg::LAST_BIT_POS) begin
                                n_phase = rc5irtx_pkg::PH_TRAIL;
                            end else begin
                                n_bit_pos = r_bit_pos + 4'd1;
                            end
                        end
                    end
                    rc5irtx_pkg::PH_GAP: begin
                        n_bit_pos     = '0;
                        n_second_half = 1'b0;
                        n_phase       = rc5irtx_pkg::PH_BIT;
                    end
                    default: begin
                        // trailing idle half ends a frame
                        n_repeats_left = w_reps_dec;
                        if (w_reps_dec == 8'd0) begin
                            n_sending              = 1'b0;
                            n_result.sequence_done = 1'b1;
                            n_phase                = rc5irtx_pkg::PH_BIT;
                        end else if (r_gap_ticks == 16'd0) begin
                            n_bit_pos     = '0;
                            n_second_half = 1'b0;
                            n_phase       = rc5irtx_pkg::PH_BIT;
                        end else begin
                            n_phase = rc5irtx_pkg::PH_GAP;
                        end
                    end
                endcase
            end
        end
        n_result.busy_res = n_sending;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending      <= 1'b0;
            r_frame_word   <= '0;
            r_bit_pos      <= '0;
            r_second_half  <= 1'b0;
            r_phase        <= rc5irtx_pkg::PH_BIT;
            r_tick_count   <= '0;
            r_repeats_left <= '0;
            r_toggle       <= 1'b0;
        end else if (w_accept) begin
            r_sending      <= n_sending;
            r_frame_word   <= n_frame_word;
            r_bit_pos      <= n_bit_pos;
            r_second_half  <= n_second_half;
            r_phase        <= n_phase;
            r_tick_count   <= n_tick_count;
            r_repeats_left <= n_repeats_left;
            r_toggle       <= n_toggle;
        end
    end

    // result buffer
    rc5irtx_pkg::t_result w_out;

    rc5irtx_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (n_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {4'b0000, w_out};

endmodule

/* src/rc5irtx_checker.sv */
`timescale 1ns / 1ps

module rc5irtx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // input side only stalls when results are queued
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("output buffer not empty after reset");

    // carrier and drop only happen while a sequence is running
    a_busy_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[3]) |-> m_axis_tdata[1])
        else $error("carrier or drop flagged while not busy");

    // sequence end clears busy and carries no carrier
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[0])
        else $error("sequence done while still busy");

endmodule

bind rc5_ir_frame_transmitter rc5irtx_checker u_rc5irtx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
